// ===== rtl/baro_pkg.sv =====
// Shared types, constants and a helper function for the barometer compensation block.
// Used by the controller, the datapath and the top level; depends on nothing.
package baro_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] CFG_AC123 = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_AC456 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_B12 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MCMD = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TLIM = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PLIM = 3'd5;

  localparam logic [15:0] TEMP_LIMIT_RST = 16'd1000;
  localparam logic [16:0] PRESS_LIMIT_RST = 17'd10000;
  localparam logic [31:0] TEMP_RST = 32'd240;
  localparam logic [31:0] PRESS_RST = 32'd102650;

  localparam logic [31:0] B6_OFFSET = 32'd4000;
  localparam logic [31:0] B4_BIAS = 32'h0000_8000;
  localparam logic [31:0] B7_SCALE = 32'd12500;
  localparam logic [31:0] P_COEF1 = 32'd3038;
  localparam logic [31:0] P_COEF2 = 32'hFFFF_E343;
  localparam logic [31:0] P_COEF3 = 32'd3791;

  typedef enum logic [4:0] {
    ST_T0, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8, ST_P9,
    ST_P10, ST_P11, ST_P12, ST_P13, ST_P14, ST_P15, ST_P16, ST_P17, ST_P18,
    ST_P19, ST_P20, ST_REJ
  } step_t;

  typedef struct packed {
    logic  load;
    logic  en;
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic zero_div;
    logic div_done;
  } sts_t;

  // Signed division by 2**k, truncating toward zero.
  function automatic logic [31:0] sdiv_pow2(logic [31:0] a, logic [4:0] k);
    logic [31:0] m;
    m = a[31] ? (32'd0 - a) : a;
    m = m >> k;
    return a[31] ? (32'd0 - m) : m;
  endfunction

endpackage

// ===== rtl/baro_if.sv =====
// Valid/ready channel interfaces for raw conversion items and compensated result items.
// Depends on nothing.
interface baro_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] raw_msb;
  logic [7:0] raw_lsb;
  logic [7:0] raw_xlsb;
  modport source (output valid, operation, raw_msb, raw_lsb, raw_xlsb, input ready);
  modport sink (input valid, operation, raw_msb, raw_lsb, raw_xlsb, output ready);
endinterface

interface baro_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature;
  logic signed [31:0] pressure;
  logic               rejected;
  modport source (output valid, temperature, pressure, rejected, input ready);
  modport sink (input valid, temperature, pressure, rejected, output ready);
endinterface

// ===== rtl/baro_ctrl.sv =====
// Controller state machine: sequences the datapath steps, waits on the divider
// and owns the input ready and output valid flags. Depends on baro_pkg.
module baro_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  baro_pkg::sts_t    sts,
  output baro_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {S_IDLE, S_BUSY, S_WAIT_DIV} state_t;

  state_t          state_r;
  baro_pkg::step_t step_r;
  logic            ready_r;
  logic            out_valid_r;
  logic            commit_step;
  logic            slot_free;

  assign commit_step = (step_r == baro_pkg::ST_T5) || (step_r == baro_pkg::ST_P20) ||
                       (step_r == baro_pkg::ST_REJ);
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd.load = (state_r == S_IDLE) && in_valid;
    cmd.en = (state_r == S_BUSY) && (!commit_step || slot_free);
    cmd.step = step_r;
  end

  assign in_ready = ready_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= baro_pkg::ST_T0;
      ready_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_BUSY) && commit_step && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && ready_r) begin
            ready_r <= 1'b0;
            state_r <= S_BUSY;
            step_r <= in_op ? baro_pkg::ST_P0 : baro_pkg::ST_T0;
          end else begin
            ready_r <= 1'b1;
          end
        end
        S_BUSY: begin
          if (commit_step) begin
            if (slot_free) begin
              state_r <= S_IDLE;
            end
          end else if ((step_r == baro_pkg::ST_T2 || step_r == baro_pkg::ST_P12) &&
                       sts.zero_div) begin
            step_r <= baro_pkg::ST_REJ;
          end else begin
            step_r <= baro_pkg::step_t'(step_r + 5'd1);
            if (step_r == baro_pkg::ST_T2 || step_r == baro_pkg::ST_P13) begin
              state_r <= S_WAIT_DIV;
            end
          end
        end
        S_WAIT_DIV: begin
          if (sts.div_done) begin
            state_r <= S_BUSY;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !ready_r)
    else $error("ready high while an item is in work");
  a_wait_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT_DIV && !sts.div_done) |=> (state_r == S_WAIT_DIV))
    else $error("left divider wait before the quotient was ready");
  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.en && commit_step) |-> (!out_valid_r || out_ready))
    else $error("result written over an item not yet taken");
`endif

endmodule

// ===== rtl/baro_dp.sv =====
// Datapath: calibration registers, compensation state, a shared 32-bit multiplier,
// a bit-serial divider and the result registers. Depends on baro_pkg.
module baro_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [baro_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [baro_pkg::CfgDataW-1:0]   cfg_wdata,
  input  logic [23:0]                     raw,
  input  baro_pkg::cmd_t                  cmd,
  output baro_pkg::sts_t                  sts,
  output logic [31:0]                     res_temp,
  output logic [31:0]                     res_press,
  output logic                            res_rej
);

  logic [47:0] ac123_r, ac456_r;
  logic [31:0] b12_r, mcmd_r;
  logic [15:0] tlim_r;
  logic [16:0] plim_r;
  logic [31:0] b5_r, last_t_r, last_p_r;
  logic [23:0] raw_r;
  logic [31:0] prod_r, x1_r, x2_r, x3_r, b3_r, b4_r, b6_r, b7_r, sq_r, p_r, new_r;
  logic [31:0] prod_nxt, x1_nxt, x2_nxt, x3_nxt, b3_nxt, b4_nxt, b6_nxt, b7_nxt;
  logic [31:0] sq_nxt, p_nxt, new_nxt, b5_nxt, last_t_nxt, last_p_nxt;
  logic [31:0] out_t_r, out_p_r, out_t_nxt, out_p_nxt;
  logic        out_rej_r, out_rej_nxt;
  logic [31:0] mul_a, mul_b;
  logic        mul_en;
  logic [31:0] ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, den, q_s, sum;
  logic        jump;
  logic        div_start, div_neg;
  logic [31:0] div_dvd, div_dvs;
  logic [31:0] rem_r, quo_r, dvs_r;
  logic        neg_r, busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [32:0] rem_sh, diff;

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic too_far(logic [31:0] old_v, logic [31:0] new_v,
                                   logic [16:0] lim);
    logic [33:0] d;
    d = {{2{old_v[31]}}, old_v} - {{2{new_v[31]}}, new_v};
    if (d[33]) begin
      d = 34'd0 - d;
    end
    return d > {17'd0, lim};
  endfunction

  assign ut = {16'd0, raw_r[23:8]};
  assign up = {14'd0, raw_r[23:6]};
  assign ac1 = sx16(ac123_r[47:32]);
  assign ac2 = sx16(ac123_r[31:16]);
  assign ac3 = sx16(ac123_r[15:0]);
  assign ac4 = {16'd0, ac456_r[47:32]};
  assign ac5 = {16'd0, ac456_r[31:16]};
  assign ac6 = {16'd0, ac456_r[15:0]};
  assign b1 = sx16(b12_r[31:16]);
  assign b2 = sx16(b12_r[15:0]);
  assign mc = sx16(mcmd_r[31:16]);
  assign md = sx16(mcmd_r[15:0]);
  assign den = x1_r + md;
  assign q_s = neg_r ? (32'd0 - quo_r) : quo_r;

  always_comb begin
    sts.div_done = done_r;
    sts.zero_div = (cmd.step == baro_pkg::ST_T2) ? (den == 32'd0) : (b4_r == 32'd0);
  end

  always_comb begin
    prod_nxt = prod_r; x1_nxt = x1_r; x2_nxt = x2_r; x3_nxt = x3_r;
    b3_nxt = b3_r; b4_nxt = b4_r; b6_nxt = b6_r; b7_nxt = b7_r; sq_nxt = sq_r;
    p_nxt = p_r; new_nxt = new_r; b5_nxt = b5_r;
    last_t_nxt = last_t_r; last_p_nxt = last_p_r;
    out_t_nxt = out_t_r; out_p_nxt = out_p_r; out_rej_nxt = out_rej_r;
    mul_a = 32'd0; mul_b = 32'd0; mul_en = 1'b0;
    div_start = 1'b0; div_neg = 1'b0; div_dvd = 32'd0; div_dvs = 32'd0;
    sum = 32'd0; jump = 1'b0;
    if (cmd.en) begin
      case (cmd.step)
        baro_pkg::ST_T0: begin
          mul_a = ut - ac6; mul_b = ac5; mul_en = 1'b1;
        end
        baro_pkg::ST_T1: x1_nxt = baro_pkg::sdiv_pow2(prod_r, 5'd15);
        baro_pkg::ST_T2: begin
          sum = mc << 11;
          div_start = (den != 32'd0);
          div_neg = sum[31] ^ den[31];
          div_dvd = sum[31] ? (32'd0 - sum) : sum;
          div_dvs = den[31] ? (32'd0 - den) : den;
        end
        baro_pkg::ST_T3: b5_nxt = x1_r + q_s;
        baro_pkg::ST_T4: new_nxt = baro_pkg::sdiv_pow2(b5_r + 32'd8, 5'd4);
        baro_pkg::ST_T5: begin
          jump = too_far(last_t_r, new_r, {1'b0, tlim_r});
          if (!jump) begin
            last_t_nxt = new_r;
          end
          out_t_nxt = jump ? last_t_r : new_r;
          out_p_nxt = last_p_r;
          out_rej_nxt = jump;
        end
        baro_pkg::ST_P0: b6_nxt = b5_r - baro_pkg::B6_OFFSET;
        baro_pkg::ST_P1: begin
          mul_a = b6_r; mul_b = b6_r; mul_en = 1'b1;
        end
        baro_pkg::ST_P2: sq_nxt = baro_pkg::sdiv_pow2(prod_r, 5'd12);
        baro_pkg::ST_P3: begin
          mul_a = b2; mul_b = sq_r; mul_en = 1'b1;
        end
        baro_pkg::ST_P4: begin
          x1_nxt = baro_pkg::sdiv_pow2(prod_r, 5'd11);
          mul_a = ac2; mul_b = b6_r; mul_en = 1'b1;
        end
        baro_pkg::ST_P5: x2_nxt = baro_pkg::sdiv_pow2(prod_r, 5'd11);
        baro_pkg::ST_P6: begin
          sum = (((ac1 << 2) + x1_r + x2_r) << 2) + 32'd2;
          b3_nxt = baro_pkg::sdiv_pow2(sum, 5'd2);
          mul_a = ac3; mul_b = b6_r; mul_en = 1'b1;
        end
        baro_pkg::ST_P7: begin
          x1_nxt = baro_pkg::sdiv_pow2(prod_r, 5'd13);
          mul_a = b1; mul_b = sq_r; mul_en = 1'b1;
        end
        baro_pkg::ST_P8: x2_nxt = baro_pkg::sdiv_pow2(prod_r, 5'd16);
        baro_pkg::ST_P9: x3_nxt = baro_pkg::sdiv_pow2(x1_r + x2_r + 32'd2, 5'd2);
        baro_pkg::ST_P10: begin
          mul_a = ac4; mul_b = x3_r + baro_pkg::B4_BIAS; mul_en = 1'b1;
        end
        baro_pkg::ST_P11: b4_nxt = prod_r >> 15;
        baro_pkg::ST_P12: begin
          mul_a = up - b3_r; mul_b = baro_pkg::B7_SCALE; mul_en = 1'b1;
        end
        baro_pkg::ST_P13: begin
          b7_nxt = prod_r;
          div_start = 1'b1;
          div_dvd = prod_r[31] ? prod_r : (prod_r << 1);
          div_dvs = b4_r;
        end
        baro_pkg::ST_P14: p_nxt = b7_r[31] ? (quo_r << 1) : quo_r;
        baro_pkg::ST_P15: begin
          x1_nxt = baro_pkg::sdiv_pow2(p_r, 5'd8);
          mul_a = baro_pkg::P_COEF2; mul_b = p_r; mul_en = 1'b1;
        end
        baro_pkg::ST_P16: begin
          x2_nxt = baro_pkg::sdiv_pow2(prod_r, 5'd16);
          mul_a = x1_r; mul_b = x1_r; mul_en = 1'b1;
        end
        baro_pkg::ST_P17: begin
          mul_a = prod_r; mul_b = baro_pkg::P_COEF1; mul_en = 1'b1;
        end
        baro_pkg::ST_P18: x1_nxt = baro_pkg::sdiv_pow2(prod_r, 5'd16);
        baro_pkg::ST_P19: begin
          new_nxt = p_r + baro_pkg::sdiv_pow2(x1_r + x2_r + baro_pkg::P_COEF3, 5'd4);
        end
        baro_pkg::ST_P20: begin
          jump = too_far(last_p_r, new_r, plim_r);
          if (!jump) begin
            last_p_nxt = new_r;
          end
          out_t_nxt = last_t_r;
          out_p_nxt = jump ? last_p_r : new_r;
          out_rej_nxt = jump;
        end
        baro_pkg::ST_REJ: begin
          out_t_nxt = last_t_r;
          out_p_nxt = last_p_r;
          out_rej_nxt = 1'b1;
        end
        default: begin
          mul_en = 1'b0;
        end
      endcase
    end
    if (mul_en) begin
      prod_nxt = mul_a * mul_b;
    end
  end

  assign rem_sh = {rem_r, quo_r[31]};
  assign diff = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac123_r <= '0;
      ac456_r <= '0;
      b12_r <= '0;
      mcmd_r <= '0;
      tlim_r <= baro_pkg::TEMP_LIMIT_RST;
      plim_r <= baro_pkg::PRESS_LIMIT_RST;
      b5_r <= '0;
      last_t_r <= baro_pkg::TEMP_RST;
      last_p_r <= baro_pkg::PRESS_RST;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          baro_pkg::CFG_AC123: ac123_r <= cfg_wdata;
          baro_pkg::CFG_AC456: ac456_r <= cfg_wdata;
          baro_pkg::CFG_B12: b12_r <= cfg_wdata[31:0];
          baro_pkg::CFG_MCMD: mcmd_r <= cfg_wdata[31:0];
          baro_pkg::CFG_TLIM: tlim_r <= cfg_wdata[15:0];
          baro_pkg::CFG_PLIM: plim_r <= cfg_wdata[16:0];
          default: begin
          end
        endcase
      end
      b5_r <= b5_nxt;
      last_t_r <= last_t_nxt;
      last_p_r <= last_p_nxt;
      done_r <= busy_r && (cnt_r == 5'd31);
      if (div_start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_r <= raw;
    end
    prod_r <= prod_nxt; x1_r <= x1_nxt; x2_r <= x2_nxt; x3_r <= x3_nxt;
    b3_r <= b3_nxt; b4_r <= b4_nxt; b6_r <= b6_nxt; b7_r <= b7_nxt;
    sq_r <= sq_nxt; p_r <= p_nxt; new_r <= new_nxt;
    out_t_r <= out_t_nxt; out_p_r <= out_p_nxt; out_rej_r <= out_rej_nxt;
    if (div_start) begin
      rem_r <= '0;
      quo_r <= div_dvd;
      dvs_r <= div_dvs;
      neg_r <= div_neg;
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_r <= diff[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_sh[31:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  assign res_temp = out_t_r;
  assign res_press = out_p_r;
  assign res_rej = out_rej_r;

endmodule

// ===== rtl/barometer_compensation.sv =====
// Top level of the barometer compensation block: joins the controller and the datapath.
// Depends on baro_pkg, baro_if, baro_ctrl and baro_dp.
//
// Raw conversion items arrive on in_item, tagged by operation as a temperature or a
// pressure conversion; one result item per input item leaves on out_item with the
// temperature and pressure held after that item and a rejected flag.
// Calibration and jump limits are written through cfg_we, cfg_index and cfg_wdata;
// the user must write them only while the block is idle, as the block does not
// enforce it. Writes to unused indices are ignored. One item is in work at a time.
// After a result is raised the controller returns to idle and then raises input ready.
// Each item steps through the single shared multiplier and the bit-serial divider.
// A zero divisor shortens the path: the division is skipped and the item is rejected.
// The result sits in an output register; the next item is accepted while it waits,
// and a finished item holds in the controller until the register is free.
// After reset the calibration is zero, the limits are 1000 and 10000, b5 is zero,
// the temperature is 240 and the pressure 102650; no result is pending.
module barometer_compensation (
  input  logic                            clk,
  input  logic                            rst_n,
  baro_in_if.sink                         in_item,
  baro_out_if.source                      out_item,
  input  logic                            cfg_we,
  input  logic [baro_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [baro_pkg::CfgDataW-1:0]   cfg_wdata
);

  baro_pkg::cmd_t cmd;
  baro_pkg::sts_t sts;
  logic [31:0]    res_temp, res_press;
  logic           res_rej;

  baro_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_op     (in_item.operation),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  baro_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .raw       ({in_item.raw_msb, in_item.raw_lsb, in_item.raw_xlsb}),
    .cmd       (cmd),
    .sts       (sts),
    .res_temp  (res_temp),
    .res_press (res_press),
    .res_rej   (res_rej)
  );

  assign out_item.temperature = res_temp;
  assign out_item.pressure = res_press;
  assign out_item.rejected = res_rej;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for barometer_compensation; depends on it, baro_pkg and baro_if.
// Directed table then random items, checked by an in-bench integer compensation predictor.
module tb_top;

  localparam logic OP_TEMP = 1'b0;
  localparam logic OP_PRESS = 1'b1;
  localparam int unsigned CycleLimit = 1500000;

  typedef struct packed {
    logic       op;
    logic [7:0] msb;
    logic [7:0] lsb;
    logic [7:0] xlsb;
  } raw_item_t;

  typedef struct packed {
    logic [31:0] temperature;
    logic [31:0] pressure;
    logic        rejected;
  } comp_result_t;

  typedef struct {
    raw_item_t    item;
    logic         has_exp;
    comp_result_t exp_res;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [baro_pkg::CfgIdxW-1:0] cfg_index;
  logic [baro_pkg::CfgDataW-1:0] cfg_wdata;

  baro_in_if in_item();
  baro_out_if out_item();

  barometer_compensation uut (
    .clk(clk), .rst_n(rst_n), .in_item(in_item.sink), .out_item(out_item.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predictor state.
  logic [47:0] m_ac123, m_ac456;
  logic [31:0] m_b12, m_mcmd;
  logic [31:0] m_tlim, m_plim;
  logic [31:0] m_b5, m_temp, m_press;

  comp_result_t expected_q[$];
  int errors;
  int send_idle_pct, recv_stall_pct;
  int unsigned cycles;
  int sent, got;

  function automatic logic [31:0] sext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  function automatic logic jump_exceeds(logic [31:0] old_v, logic [31:0] new_v,
                                        logic [31:0] lim);
    longint d;
    d = longint'(signed'(old_v)) - longint'(signed'(new_v));
    if (d < 0) d = -d;
    return d > longint'(lim);
  endfunction

  function automatic logic compensate_temp(logic [31:0] ut);
    logic [31:0] ac5, ac6, mc, md, x1, den, x2, t;
    ac5 = {16'd0, m_ac456[31:16]};
    ac6 = {16'd0, m_ac456[15:0]};
    mc = sext16(m_mcmd[31:16]);
    md = sext16(m_mcmd[15:0]);
    x1 = div_trunc((ut - ac6) * ac5, 32'h8000);
    den = x1 + md;
    if (den == 0) return 1'b1;
    x2 = div_trunc(mc * 32'h800, den);
    m_b5 = x1 + x2;
    t = div_trunc(m_b5 + 32'd8, 32'd16);
    if (jump_exceeds(m_temp, t, m_tlim)) return 1'b1;
    m_temp = t;
    return 1'b0;
  endfunction

  function automatic logic compensate_press(logic [31:0] up);
    logic [31:0] ac1, ac2, ac3, ac4, b1, b2, b6, sq, x1, x2, x3, b3, b4, b7, p;
    ac1 = sext16(m_ac123[47:32]);
    ac2 = sext16(m_ac123[31:16]);
    ac3 = sext16(m_ac123[15:0]);
    ac4 = {16'd0, m_ac456[47:32]};
    b1 = sext16(m_b12[31:16]);
    b2 = sext16(m_b12[15:0]);
    b6 = m_b5 - 32'd4000;
    sq = div_trunc(b6 * b6, 32'h1000);
    x1 = div_trunc(b2 * sq, 32'h800);
    x2 = div_trunc(ac2 * b6, 32'h800);
    x3 = x1 + x2;
    b3 = div_trunc((ac1 * 32'd4 + x3) * 32'd4 + 32'd2, 32'd4);
    x1 = div_trunc(ac3 * b6, 32'h2000);
    x2 = div_trunc(b1 * sq, 32'h10000);
    x3 = div_trunc(x1 + x2 + 32'd2, 32'd4);
    b4 = (ac4 * (x3 + 32'd32768)) / 32'h8000;
    if (b4 == 0) return 1'b1;
    b7 = (up - b3) * 32'd12500;
    if (!b7[31]) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    x1 = div_trunc(p, 32'h100);
    x1 = x1 * x1;
    x1 = div_trunc(x1 * 32'd3038, 32'h10000);
    x2 = div_trunc((32'd0 - 32'd7357) * p, 32'h10000);
    p = p + div_trunc(x1 + x2 + 32'd3791, 32'd16);
    if (jump_exceeds(m_press, p, m_plim)) return 1'b1;
    m_press = p;
    return 1'b0;
  endfunction

  function automatic comp_result_t predict_item(raw_item_t it);
    comp_result_t r;
    if (it.op == OP_TEMP) r.rejected = compensate_temp({16'd0, it.msb, it.lsb});
    else r.rejected = compensate_press({8'd0, it.msb, it.lsb, it.xlsb} >> 6);
    r.temperature = m_temp;
    r.pressure = m_press;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result checking and receiver stalls.
  always @(posedge clk) begin
    comp_result_t act, exp_r;
    if (rst_n && out_item.valid && out_item.ready) begin
      act = {out_item.temperature, out_item.pressure, out_item.rejected};
      got <= got + 1;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, act);
      end else begin
        exp_r = expected_q.pop_front();
        if (act.temperature !== exp_r.temperature) begin
          errors++;
          $display("%0t: temperature expected %0d actual %0d", $time,
                   signed'(exp_r.temperature), signed'(act.temperature));
        end
        if (act.pressure !== exp_r.pressure) begin
          errors++;
          $display("%0t: pressure expected %0d actual %0d", $time,
                   signed'(exp_r.pressure), signed'(act.pressure));
        end
        if (act.rejected !== exp_r.rejected) begin
          errors++;
          $display("%0t: rejected expected %0b actual %0b", $time,
                   exp_r.rejected, act.rejected);
        end
      end
    end
    out_item.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(logic [baro_pkg::CfgIdxW-1:0] idx,
                           logic [baro_pkg::CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      baro_pkg::CFG_AC123: m_ac123 = val[47:0];
      baro_pkg::CFG_AC456: m_ac456 = val[47:0];
      baro_pkg::CFG_B12: m_b12 = val[31:0];
      baro_pkg::CFG_MCMD: m_mcmd = val[31:0];
      baro_pkg::CFG_TLIM: m_tlim = {16'd0, val[15:0]};
      baro_pkg::CFG_PLIM: m_plim = {15'd0, val[16:0]};
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Sends one item; valid stays high into the next item when no gap is drawn.
  task automatic send_item(raw_item_t it, logic has_exp, comp_result_t exp_r);
    comp_result_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_item.valid <= 1'b0;
      @(posedge clk);
    end
    in_item.valid <= 1'b1;
    in_item.operation <= it.op;
    in_item.raw_msb <= it.msb;
    in_item.raw_lsb <= it.lsb;
    in_item.raw_xlsb <= it.xlsb;
    @(posedge clk);
    while (!in_item.ready) @(posedge clk);
    p = predict_item(it);
    if (has_exp && p !== exp_r) begin
      errors++;
      $display("%0t: table row expected %h predictor %h", $time, exp_r, p);
    end
    expected_q.push_back(p);
    sent++;
  endtask

  task automatic send_random(int n, logic plausible);
    raw_item_t it;
    comp_result_t none;
    none = '0;
    for (int i = 0; i < n; i++) begin
      it = {1'($urandom_range(1)), 8'($urandom), 8'($urandom), 8'($urandom)};
      if (plausible && $urandom_range(3) != 0) begin
        if (it.op == OP_TEMP) it.msb = 8'($urandom_range(8'h58, 8'h78));
        else it.msb = 8'($urandom_range(8'h98, 8'hB4));
      end
      send_item(it, 1'b0, none);
    end
    in_item.valid <= 1'b0;
  endtask

  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0; recv_stall_pct = 0; end
      1: begin send_idle_pct = 59; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 59; end
      default: begin send_idle_pct = 26; recv_stall_pct = 26; end
    endcase
  endtask

  dir_row_t dir_table[$];

  task automatic add_row(logic op, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                         logic has_exp, logic [31:0] t, logic [31:0] p, logic rj);
    dir_row_t r;
    r.item = {op, a, b, c};
    r.has_exp = has_exp;
    r.exp_res = {t, p, rj};
    dir_table.push_back(r);
  endtask

  initial begin
    errors = 0; cycles = 0; sent = 0; got = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_item.valid = 1'b0; in_item.operation = 1'b0;
    in_item.raw_msb = '0; in_item.raw_lsb = '0; in_item.raw_xlsb = '0;
    out_item.ready = 1'b0;
    m_ac123 = '0; m_ac456 = '0; m_b12 = '0; m_mcmd = '0;
    m_tlim = 32'(baro_pkg::TEMP_LIMIT_RST); m_plim = 32'(baro_pkg::PRESS_LIMIT_RST);
    m_b5 = '0; m_temp = baro_pkg::TEMP_RST; m_press = baro_pkg::PRESS_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With zero calibration both divisors are zero, so the reset values come back.
    add_row(OP_TEMP, 8'h00, 8'h00, 8'h00, 1'b1, baro_pkg::TEMP_RST, baro_pkg::PRESS_RST,
            1'b1);
    add_row(OP_PRESS, 8'hFF, 8'hFF, 8'hFF, 1'b1, baro_pkg::TEMP_RST, baro_pkg::PRESS_RST,
            1'b1);
    foreach (dir_table[i]) send_item(dir_table[i].item, dir_table[i].has_exp,
                                     dir_table[i].exp_res);
    in_item.valid <= 1'b0;
    drain();

    // Typical datasheet calibration.
    write_reg(baro_pkg::CFG_AC123, {16'd408, 16'hFFD2, 16'hC5E5});
    write_reg(baro_pkg::CFG_AC456, {16'd32741, 16'd32757, 16'd23153});
    write_reg(baro_pkg::CFG_B12, {16'd6190, 16'd4});
    write_reg(baro_pkg::CFG_MCMD, {16'hD4BD, 16'd2868});
    write_reg(baro_pkg::CFG_TLIM, 48'd65535);
    write_reg(baro_pkg::CFG_PLIM, 48'd131071);
    dir_table.delete();
    add_row(OP_TEMP, 8'h6C, 8'hFA, 8'h00, 1'b0, 32'd0, 32'd0, 1'b0);
    add_row(OP_PRESS, 8'h5D, 8'h23, 8'h00, 1'b0, 32'd0, 32'd0, 1'b0);
    add_row(OP_TEMP, 8'hFF, 8'hFF, 8'hFF, 1'b0, 32'd0, 32'd0, 1'b0);
    add_row(OP_PRESS, 8'hFF, 8'hFF, 8'hFF, 1'b0, 32'd0, 32'd0, 1'b0);
    add_row(OP_TEMP, 8'h00, 8'h00, 8'h00, 1'b0, 32'd0, 32'd0, 1'b0);
    add_row(OP_PRESS, 8'h00, 8'h00, 8'h00, 1'b0, 32'd0, 32'd0, 1'b0);
    add_row(OP_TEMP, 8'h6C, 8'hFA, 8'hAA, 1'b0, 32'd0, 32'd0, 1'b0);
    add_row(OP_PRESS, 8'hAA, 8'h55, 8'hC0, 1'b0, 32'd0, 32'd0, 1'b0);
    foreach (dir_table[i]) send_item(dir_table[i].item, dir_table[i].has_exp,
                                     dir_table[i].exp_res);
    in_item.valid <= 1'b0;
    drain();

    // Zero limits: any change is a jump.
    write_reg(baro_pkg::CFG_TLIM, 48'd0);
    write_reg(baro_pkg::CFG_PLIM, 48'd0);
    send_random(10, 1'b1);
    drain();
    write_reg(baro_pkg::CFG_TLIM, 48'd1000);
    write_reg(baro_pkg::CFG_PLIM, 48'd10000);

    for (int ph = 0; ph < 12; ph++) begin
      set_idling(ph);
      if (ph % 3 == 2) begin
        write_reg(baro_pkg::CFG_AC123, {16'($urandom), 32'($urandom)});
        write_reg(baro_pkg::CFG_AC456, {16'($urandom), 32'($urandom)});
        write_reg(baro_pkg::CFG_B12, 48'($urandom));
        write_reg(baro_pkg::CFG_MCMD, 48'($urandom));
        write_reg(baro_pkg::CFG_TLIM, 48'($urandom_range(65535)));
        write_reg(baro_pkg::CFG_PLIM, 48'($urandom_range(131071)));
      end else if (ph % 3 == 0) begin
        write_reg(baro_pkg::CFG_AC123, {16'd408, 16'hFFD2, 16'hC5E5});
        write_reg(baro_pkg::CFG_AC456, {16'd32741, 16'd32757, 16'd23153});
        write_reg(baro_pkg::CFG_B12, {16'd6190, 16'd4});
        write_reg(baro_pkg::CFG_MCMD, {16'hD4BD, 16'd2868});
        write_reg(baro_pkg::CFG_TLIM, ph == 6 ? 48'd65535 : 48'd1000);
        write_reg(baro_pkg::CFG_PLIM, ph == 6 ? 48'd131071 : 48'd10000);
      end
      send_random(36, ph % 3 != 2);
      drain();
    end

    if (errors == 0 && expected_q.size() == 0 && got == sent) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== barometer_compensation.f =====
rtl/baro_pkg.sv
rtl/baro_if.sv
rtl/baro_ctrl.sv
rtl/baro_dp.sv
rtl/barometer_compensation.sv
verif/tb_top.sv
